// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the sprite compositor RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, muted while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/scc_pkg.sv =====
// Shared types, constants and helpers of the sprite scanline compositor.
// Depends on nothing; used by every RTL module of the block except scc_ram.
`default_nettype none

package scc_pkg;

   localparam int SPRITE_SLOTS_DEF = 64;
   localparam int MAX_SPRITE_DIM   = 256;
   localparam int LINE_WIDTH       = 1024;

   localparam int DIM_W  = 9;
   localparam int POS_W  = 11;
   localparam int ROW_W  = 10;
   localparam int COL_W  = 8;
   localparam int PIX_W  = 32;
   localparam int ADDR_W = 10;
   localparam int BYTE_W = 8;
   localparam int SIDX_W = 6;
   localparam int CSR_W  = 11;

   localparam logic OP_WRITE_ENTRY = 1'b0;
   localparam logic OP_COMPOSITE   = 1'b1;

   localparam logic CSR_SCAN_WIDTH = 1'b0;
   localparam logic CSR_SYNC_BYTE  = 1'b1;

   localparam logic [POS_W-1:0]  SCAN_WIDTH_RESET = 11'd640;
   localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET  = 8'h00;

   localparam logic [PIX_W-1:0]  ALPHA8888_MASK  = 32'hFF00_0000;
   localparam logic [BYTE_W-1:0] ALPHA2222_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] COLOUR2222_MASK = 8'h3F;
   localparam logic [ADDR_W-1:0] ADDR_SWIZZLE    = 10'd2;

   typedef logic [0:0] fmt_type;
   localparam fmt_type FMT_RGBA8888 = 1'b0;
   localparam fmt_type FMT_RGBA2222 = 1'b1;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [DIM_W-1:0]        w;
      logic [DIM_W-1:0]        h;
      fmt_type                 fmt;
      logic                    en;
   } sprite_entry_type;

   localparam int ENTRY_W = $bits(sprite_entry_type);

   typedef struct packed {
      logic              opcode;
      logic              in_range;
      logic [ROW_W-1:0]  scan_row;
      logic [COL_W-1:0]  column;
      logic [PIX_W-1:0]  source_pixel;
   } pixel_req_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [BYTE_W-1:0] write_byte;
   } write_result_type;

   // Clamp a frame dimension to the largest supported sprite.
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (int'(v) > MAX_SPRITE_DIM) begin
         r = DIM_W'(MAX_SPRITE_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module scc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/scc_table.sv =====
// Sprite attribute table: RAM plus per-entry valid bits for reset.
// Depends on scc_pkg and scc_ram.
`default_nettype none

module scc_table #(
   parameter int SPRITE_SLOTS = scc_pkg::SPRITE_SLOTS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic                       rd_en,
   input  wire logic [((SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1)-1:0] addr,
   input  wire logic                       in_range,
   input  wire scc_pkg::sprite_entry_type  wr_entry,
   output      scc_pkg::sprite_entry_type  rd_entry
);
   import scc_pkg::*;

   logic [SPRITE_SLOTS-1:0] valid_ff, valid_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [ENTRY_W-1:0]      ram_rd_data;

   scc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SPRITE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en && in_range),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en && in_range) begin
         valid_in[addr] = 1'b1;
      end
   end

   // an entry never written reads as disabled
   assign rd_valid_in = in_range && valid_ff[addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= rd_valid_in;
         end
      end
   end

   assign rd_entry = rd_valid_ff ? sprite_entry_type'(ram_rd_data) : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/scc_shade.sv =====
// Pixel evaluation: row/column test, clipping, alpha test and colour packing.
// Depends on scc_pkg.
`default_nettype none

module scc_shade (
   input  wire scc_pkg::sprite_entry_type  entry,
   input  wire scc_pkg::pixel_req_type     req,
   input  wire logic [scc_pkg::POS_W-1:0]  scan_width,
   input  wire logic [scc_pkg::BYTE_W-1:0] sync_byte,
   output      scc_pkg::write_result_type  result
);
   import scc_pkg::*;

   logic signed [POS_W:0] row_s, y_s, y_end, x_s, pos;
   logic [POS_W-1:0]      pos_low;
   logic                  row_ok, col_ok, pos_ok, opaque, hit;
   logic [5:0]            colour;

   always_comb begin
      row_s   = $signed({2'b00, req.scan_row});
      y_s     = $signed({entry.y[POS_W-1], entry.y});
      y_end   = y_s + $signed({3'b000, entry.h});
      x_s     = $signed({entry.x[POS_W-1], entry.x});
      pos     = x_s + $signed({4'b0000, req.column});
      pos_low = pos[POS_W-1:0];

      row_ok = (row_s >= y_s) && (row_s < y_end);
      col_ok = {1'b0, req.column} < entry.w;
      pos_ok = !pos[POS_W] && (pos_low < scan_width) &&
               (32'(pos_low) < 32'(LINE_WIDTH));

      if (entry.fmt == FMT_RGBA8888) begin
         opaque = (req.source_pixel & ALPHA8888_MASK) != '0;
         colour = {req.source_pixel[23:22], req.source_pixel[15:14],
                   req.source_pixel[7:6]};
      end else begin
         opaque = (req.source_pixel[BYTE_W-1:0] & ALPHA2222_MASK) != '0;
         colour = 6'(req.source_pixel[BYTE_W-1:0] & COLOUR2222_MASK);
      end

      hit = (req.opcode == OP_COMPOSITE) && req.in_range && entry.en &&
            row_ok && col_ok && pos_ok && opaque;

      result.write_valid   = hit;
      result.write_address = hit ? (pos[ADDR_W-1:0] ^ ADDR_SWIZZLE) : '0;
      result.write_byte    = hit ? ({2'b00, colour} | sync_byte) : '0;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_scanline_compositor.sv =====
// A taken word is registered in req_ff beside its table read, then its result in result_ff.
// Throughput: one word per clock once busy is low; busy clears after reset falls, then stays low.
// The table RAM is read and written at the accepting edge, so neighbours never collide.
// Every word, table write included, yields exactly one rsp_valid strobe.
// Reset (synchronous, high) disables all table entries via valid bits and
// restores scan_width 640 and sync_byte 0; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module sprite_scanline_compositor #(
   parameter int SPRITE_SLOTS = scc_pkg::SPRITE_SLOTS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic                         req_opcode,
   input  wire logic [scc_pkg::SIDX_W-1:0]   req_sprite_index,
   input  wire logic signed [scc_pkg::POS_W-1:0] req_sprite_x,
   input  wire logic signed [scc_pkg::POS_W-1:0] req_sprite_y,
   input  wire logic [scc_pkg::DIM_W-1:0]    req_sprite_width,
   input  wire logic [scc_pkg::DIM_W-1:0]    req_sprite_height,
   input  wire logic                         req_pixel_format,
   input  wire logic                         req_sprite_enabled,
   input  wire logic [scc_pkg::ROW_W-1:0]    req_scan_row,
   input  wire logic [scc_pkg::COL_W-1:0]    req_column,
   input  wire logic [scc_pkg::PIX_W-1:0]    req_source_pixel,
   output      logic                         rsp_valid,
   output      logic                         rsp_write_valid,
   output      logic [scc_pkg::ADDR_W-1:0]   rsp_write_address,
   output      logic [scc_pkg::BYTE_W-1:0]   rsp_write_byte,
   input  wire logic                         csr_write_enable,
   input  wire logic                         csr_index,
   input  wire logic [scc_pkg::CSR_W-1:0]    csr_write_data
);
   import scc_pkg::*;

   localparam int IDX_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;

   logic             accept;
   logic             entry_write;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] table_addr;
   logic             in_range;
   sprite_entry_type wr_entry, rd_entry;

   // stage 1: request held while the table read completes
   logic             stage_ff, stage_in;
   pixel_req_type    req_ff, req_in;

   // stage 2: result word
   logic             rsp_valid_ff, rsp_valid_in;
   write_result_type result_ff, result_in;

   logic [POS_W-1:0]  scan_width_ff, scan_width_in;
   logic [BYTE_W-1:0] sync_byte_ff, sync_byte_in;

   logic             idle_word;
   logic             fields_clear;

   // hold busy through reset only; the block takes a word every cycle after
   assign busy_in = 1'b0;
   assign busy    = busy_ff;
   assign accept  = start && !busy;

   assign entry_write = accept && (req_opcode == OP_WRITE_ENTRY);

   assign table_addr = IDX_W'(req_sprite_index);
   assign in_range   = 32'(req_sprite_index) < 32'(SPRITE_SLOTS);

   // clamp oversized frames as the entry is stored
   always_comb begin
      wr_entry.x   = req_sprite_x;
      wr_entry.y   = req_sprite_y;
      wr_entry.w   = sat_dim(req_sprite_width);
      wr_entry.h   = sat_dim(req_sprite_height);
      wr_entry.fmt = fmt_type'(req_pixel_format);
      wr_entry.en  = req_sprite_enabled;
   end

   scc_table #(
      .SPRITE_SLOTS (SPRITE_SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_write),
      .rd_en    (accept),
      .addr     (table_addr),
      .in_range (in_range),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   always_comb begin
      stage_in = accept;
      req_in   = req_ff;
      if (accept) begin
         req_in.opcode       = req_opcode;
         req_in.in_range     = in_range;
         req_in.scan_row     = req_scan_row;
         req_in.column       = req_column;
         req_in.source_pixel = req_source_pixel;
      end
   end

   scc_shade u_shade (
      .entry      (rd_entry),
      .req        (req_ff),
      .scan_width (scan_width_ff),
      .sync_byte  (sync_byte_ff),
      .result     (result_in)
   );

   assign rsp_valid_in = stage_ff;

   // configuration decode
   always_comb begin
      scan_width_in = scan_width_ff;
      sync_byte_in  = sync_byte_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCAN_WIDTH: scan_width_in = csr_write_data;
            CSR_SYNC_BYTE:  sync_byte_in  = csr_write_data[BYTE_W-1:0];
            default:        scan_width_in = scan_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         stage_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_width_ff <= SCAN_WIDTH_RESET;
         sync_byte_ff  <= SYNC_BYTE_RESET;
      end else begin
         busy_ff       <= busy_in;
         stage_ff      <= stage_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_width_ff <= scan_width_in;
         sync_byte_ff  <= sync_byte_in;
      end
   end

   // payload: no reset, qualified by the strobes
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      result_ff <= result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_valid_ff && result_ff.write_valid;
   assign rsp_write_address = result_ff.write_address;
   assign rsp_write_byte    = result_ff.write_byte;

   assign idle_word    = rsp_valid && !rsp_write_valid;
   assign fields_clear = (rsp_write_address == '0) && (rsp_write_byte == '0);

   `ASSERT_NEXT(a_word_in_flight, clock, reset, accept, stage_ff)
   `ASSERT_NEXT(a_strobe_follows, clock, reset, stage_ff, rsp_valid)
   `ASSERT_NEXT(a_table_write_silent, clock, reset, entry_write, !result_in.write_valid)
   `ASSERT_IMPLIES(a_idle_fields_zero, clock, reset, idle_word, fields_clear)

endmodule

`default_nettype wire

// ===== verif/sprite_scanline_compositor_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sprite scanline compositor: watches the word, result and register
// channels, predicts every line-buffer write and compares it. Depends on scc_pkg.
module sprite_scanline_compositor_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_opcode,
   input  logic [scc_pkg::SIDX_W-1:0]       req_sprite_index,
   input  logic signed [scc_pkg::POS_W-1:0] req_sprite_x,
   input  logic signed [scc_pkg::POS_W-1:0] req_sprite_y,
   input  logic [scc_pkg::DIM_W-1:0]        req_sprite_width,
   input  logic [scc_pkg::DIM_W-1:0]        req_sprite_height,
   input  logic                             req_pixel_format,
   input  logic                             req_sprite_enabled,
   input  logic [scc_pkg::ROW_W-1:0]        req_scan_row,
   input  logic [scc_pkg::COL_W-1:0]        req_column,
   input  logic [scc_pkg::PIX_W-1:0]        req_source_pixel,
   input  logic                             rsp_valid,
   input  logic                             rsp_write_valid,
   input  logic [scc_pkg::ADDR_W-1:0]       rsp_write_address,
   input  logic [scc_pkg::BYTE_W-1:0]       rsp_write_byte,
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [scc_pkg::CSR_W-1:0]        csr_write_data,
   output int                               fail_count,
   output int                               pending
);

   localparam int SLOTS = scc_pkg::SPRITE_SLOTS_DEF;

   typedef struct {
      int               x;
      int               y;
      int               w;
      int               h;
      scc_pkg::fmt_type fmt;
      bit               en;
   } sprite_attr_type;

   sprite_attr_type            sprite_slots [SLOTS];
   int                         visible_width;
   logic [scc_pkg::BYTE_W-1:0] sync_bits;
   scc_pkg::write_result_type  line_writes_due [$];

   // Work out the line-buffer write that one source pixel causes.
   function automatic scc_pkg::write_result_type composite_pixel(
      input logic [scc_pkg::SIDX_W-1:0] idx,
      input logic [scc_pkg::ROW_W-1:0]  row,
      input logic [scc_pkg::COL_W-1:0]  col,
      input logic [scc_pkg::PIX_W-1:0]  pixel
   );
      scc_pkg::write_result_type res;
      sprite_attr_type           s;
      int                        pos;
      logic                      opaque;
      logic [5:0]                colour;
      res = '0;
      s   = sprite_slots[idx];
      pos = s.x + int'(col);
      if (!s.en || int'(row) < s.y || int'(row) >= s.y + s.h || int'(col) >= s.w) begin
         return res;
      end
      if (pos < 0 || pos >= visible_width || pos >= scc_pkg::LINE_WIDTH) begin
         return res;
      end
      if (s.fmt == scc_pkg::FMT_RGBA8888) begin
         opaque = (pixel & scc_pkg::ALPHA8888_MASK) != '0;
         colour = {pixel[23:22], pixel[15:14], pixel[7:6]};
      end else begin
         opaque = (pixel[7:0] & scc_pkg::ALPHA2222_MASK) != '0;
         colour = pixel[5:0];
      end
      if (!opaque) begin
         return res;
      end
      res.write_valid   = 1'b1;
      res.write_address = pos[scc_pkg::ADDR_W-1:0] ^ scc_pkg::ADDR_SWIZZLE;
      res.write_byte    = {2'b00, colour} | sync_bits;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      scc_pkg::write_result_type due;
      if (reset) begin
         foreach (sprite_slots[i]) begin
            sprite_slots[i] = '{x: 0, y: 0, w: 0, h: 0,
                                fmt: scc_pkg::FMT_RGBA8888, en: 1'b0};
         end
         visible_width = int'(scc_pkg::SCAN_WIDTH_RESET);
         sync_bits     = scc_pkg::SYNC_BYTE_RESET;
         line_writes_due.delete();
         fail_count    = 0;
      end else begin
         if (rsp_valid) begin
            if (line_writes_due.size() == 0) begin
               $display("%0t: result with none due: valid=%0d addr=%0d byte=%02h",
                        $time, rsp_write_valid, rsp_write_address, rsp_write_byte);
               fail_count++;
            end else begin
               due = line_writes_due.pop_front();
               if (rsp_write_valid !== due.write_valid ||
                   rsp_write_address !== due.write_address ||
                   rsp_write_byte !== due.write_byte) begin
                  $display("%0t: line write mismatch: expected valid=%0d addr=%0d byte=%02h",
                           $time, due.write_valid, due.write_address, due.write_byte,
                           ", got valid=%0d addr=%0d byte=%02h",
                           rsp_write_valid, rsp_write_address, rsp_write_byte);
                  fail_count++;
               end
            end
         end
         if (csr_write_enable) begin
            if (csr_index == scc_pkg::CSR_SCAN_WIDTH) begin
               visible_width = int'(csr_write_data);
            end else begin
               sync_bits = csr_write_data[scc_pkg::BYTE_W-1:0];
            end
         end
         if (start && !busy) begin
            if (req_opcode == scc_pkg::OP_WRITE_ENTRY) begin
               sprite_slots[req_sprite_index] = '{
                  x:   int'(req_sprite_x),
                  y:   int'(req_sprite_y),
                  w:   (int'(req_sprite_width) > scc_pkg::MAX_SPRITE_DIM) ?
                          scc_pkg::MAX_SPRITE_DIM : int'(req_sprite_width),
                  h:   (int'(req_sprite_height) > scc_pkg::MAX_SPRITE_DIM) ?
                          scc_pkg::MAX_SPRITE_DIM : int'(req_sprite_height),
                  fmt: scc_pkg::fmt_type'(req_pixel_format),
                  en:  req_sprite_enabled
               };
               line_writes_due.push_back('0);
            end else begin
               line_writes_due.push_back(composite_pixel(req_sprite_index, req_scan_row,
                                                         req_column, req_source_pixel));
            end
         end
      end
      pending = line_writes_due.size();
   end

endmodule

// ===== verif/sprite_scanline_compositor_tb.sv =====
`timescale 1ns / 1ps
// Top of the sprite scanline compositor testbench: clock, reset, word and register stimulus
// and the verdict. Depends on scc_pkg, the block and sprite_scanline_compositor_checker.
module sprite_scanline_compositor_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;     // result passes req_ff and result_ff after the accepting edge
   localparam int PHASE_WORDS  = 142;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic                             req_opcode;
   logic [scc_pkg::SIDX_W-1:0]       req_sprite_index;
   logic signed [scc_pkg::POS_W-1:0] req_sprite_x;
   logic signed [scc_pkg::POS_W-1:0] req_sprite_y;
   logic [scc_pkg::DIM_W-1:0]        req_sprite_width;
   logic [scc_pkg::DIM_W-1:0]        req_sprite_height;
   logic                             req_pixel_format;
   logic                             req_sprite_enabled;
   logic [scc_pkg::ROW_W-1:0]        req_scan_row;
   logic [scc_pkg::COL_W-1:0]        req_column;
   logic [scc_pkg::PIX_W-1:0]        req_source_pixel;
   logic                             rsp_valid;
   logic                             rsp_write_valid;
   logic [scc_pkg::ADDR_W-1:0]       rsp_write_address;
   logic [scc_pkg::BYTE_W-1:0]       rsp_write_byte;
   logic                             csr_write_enable;
   logic                             csr_index;
   logic [scc_pkg::CSR_W-1:0]        csr_write_data;
   int                               fail_count;
   int                               pending;
   int                               cycle_count = 0;

   // Stimulus-side copy of what has been written to the table, used only to aim
   // pixels at visible parts of a sprite; the checker keeps its own state.
   int  aim_x [scc_pkg::SPRITE_SLOTS_DEF];
   int  aim_y [scc_pkg::SPRITE_SLOTS_DEF];
   int  aim_w [scc_pkg::SPRITE_SLOTS_DEF];
   int  aim_h [scc_pkg::SPRITE_SLOTS_DEF];
   bit  aim_fmt [scc_pkg::SPRITE_SLOTS_DEF];
   int  cur_scan_width = 640;
   bit  burst = 1'b0;                   // when set, send words back to back

   sprite_scanline_compositor u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_sprite_index   (req_sprite_index),
      .req_sprite_x       (req_sprite_x),
      .req_sprite_y       (req_sprite_y),
      .req_sprite_width   (req_sprite_width),
      .req_sprite_height  (req_sprite_height),
      .req_pixel_format   (req_pixel_format),
      .req_sprite_enabled (req_sprite_enabled),
      .req_scan_row       (req_scan_row),
      .req_column         (req_column),
      .req_source_pixel   (req_source_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_byte     (rsp_write_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   sprite_scanline_compositor_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_sprite_index   (req_sprite_index),
      .req_sprite_x       (req_sprite_x),
      .req_sprite_y       (req_sprite_y),
      .req_sprite_width   (req_sprite_width),
      .req_sprite_height  (req_sprite_height),
      .req_pixel_format   (req_pixel_format),
      .req_sprite_enabled (req_sprite_enabled),
      .req_scan_row       (req_scan_row),
      .req_column         (req_column),
      .req_source_pixel   (req_source_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_byte     (rsp_write_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** sprite_scanline_compositor: FAILED **");
         $finish;
      end
   end

   // Offer one word after an optional idle gap and hold it until the block takes it.
   // Start is only lowered when a gap is wanted, so a back-to-back word keeps it high.
   task automatic send_word(input bit op, input int idx, input int x, input int y,
                            input int w, input int h, input bit fmt, input bit en,
                            input int row, input int col, input logic [31:0] pixel);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (burst || pick < 55) begin
         gap = 0;
      end else if (pick < 88) begin
         gap = $urandom_range(1, 3);
      end else if (pick < 97) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_opcode         <= op;
      req_sprite_index   <= idx[scc_pkg::SIDX_W-1:0];
      req_sprite_x       <= x[scc_pkg::POS_W-1:0];
      req_sprite_y       <= y[scc_pkg::POS_W-1:0];
      req_sprite_width   <= w[scc_pkg::DIM_W-1:0];
      req_sprite_height  <= h[scc_pkg::DIM_W-1:0];
      req_pixel_format   <= fmt;
      req_sprite_enabled <= en;
      req_scan_row       <= row[scc_pkg::ROW_W-1:0];
      req_column         <= col[scc_pkg::COL_W-1:0];
      req_source_pixel   <= pixel;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Write a table entry; the pixel fields carry random junk the block must ignore.
   task automatic write_sprite(input int idx, input int x, input int y, input int w,
                               input int h, input bit fmt, input bit en);
      aim_x[idx]   = x;
      aim_y[idx]   = y;
      aim_w[idx]   = (w > scc_pkg::MAX_SPRITE_DIM) ? scc_pkg::MAX_SPRITE_DIM : w;
      aim_h[idx]   = (h > scc_pkg::MAX_SPRITE_DIM) ? scc_pkg::MAX_SPRITE_DIM : h;
      aim_fmt[idx] = fmt;
      send_word(scc_pkg::OP_WRITE_ENTRY, idx, x, y, w, h, fmt, en,
                $urandom, $urandom, $urandom);
   endtask

   // Present one source pixel; the entry fields carry random junk.
   task automatic composite(input int idx, input int row, input int col,
                            input logic [31:0] pixel);
      send_word(scc_pkg::OP_COMPOSITE, idx, $urandom, $urandom, $urandom, $urandom,
                1'($urandom), 1'($urandom), row, col, pixel);
   endtask

   // Drop start, wait for every due result, then let the pipeline settle.
   task automatic drain_pipeline;
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input int data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data[scc_pkg::CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (index == scc_pkg::CSR_SCAN_WIDTH) begin
         cur_scan_width = data;
      end
   endtask

   // Mostly a small working set of entries at both ends of the table, so pixels
   // land on sprites that were written recently.
   function automatic int pick_index;
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         return $urandom_range(0, 7);
      end else if (r < 8) begin
         return $urandom_range(56, 63);
      end
      return $urandom_range(0, scc_pkg::SPRITE_SLOTS_DEF - 1);
   endfunction

   // Random words: about a fifth rewrite table entries, the rest are pixels aimed
   // mostly at visible rows and columns so that clipping and alpha get exercised.
   task automatic run_random_phase(input int words);
      int               idx;
      int               x;
      int               y;
      int               w;
      int               h;
      int               row;
      int               col;
      int               lo;
      int               hi;
      int               r;
      logic [31:0]      pix;
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 39) == 0) begin
            burst = !burst;
         end
         idx = pick_index();
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               x = int'($urandom_range(0, cur_scan_width + 40)) - 40;
               y = int'($urandom_range(0, 1063)) - 40;
            end else begin
               x = int'($urandom_range(0, 2047)) - 1024;
               y = int'($urandom_range(0, 2047)) - 1024;
            end
            if (x > 1023) x = 1023;
            if (y > 1023) y = 1023;
            r = $urandom_range(0, 9);
            w = (r == 0) ? $urandom_range(0, 511) : (r == 1) ? $urandom_range(1, 4)
                                                             : $urandom_range(1, 256);
            r = $urandom_range(0, 9);
            h = (r == 0) ? $urandom_range(0, 511) : (r == 1) ? $urandom_range(1, 4)
                                                             : $urandom_range(1, 256);
            write_sprite(idx, x, y, w, h, 1'($urandom), $urandom_range(0, 9) != 0);
         end else begin
            lo  = (aim_y[idx] > 0) ? aim_y[idx] : 0;
            hi  = aim_y[idx] + aim_h[idx] - 1;
            if (hi > 1023) hi = 1023;
            row = ($urandom_range(0, 4) != 0 && lo <= hi) ? $urandom_range(lo, hi)
                                                           : $urandom_range(0, 1023);
            lo  = (aim_x[idx] < 0) ? -aim_x[idx] : 0;
            hi  = aim_w[idx] - 1;
            if (cur_scan_width - 1 - aim_x[idx] < hi) hi = cur_scan_width - 1 - aim_x[idx];
            if (1023 - aim_x[idx] < hi) hi = 1023 - aim_x[idx];
            col = ($urandom_range(0, 4) != 0 && lo <= hi) ? $urandom_range(lo, hi)
                                                           : $urandom_range(0, 255);
            pix = $urandom;
            // Clear the alpha of some pixels so that transparency is hit often.
            if ($urandom_range(0, 9) == 0) begin
               if (aim_fmt[idx] == scc_pkg::FMT_RGBA8888) begin
                  pix[31:24] = 8'h00;
               end else begin
                  pix[7:6] = 2'b00;
               end
            end
            composite(idx, row, col, pix);
         end
      end
   endtask

   initial begin
      int sw;
      int sb;
      // Every input known from time zero; reset asserted once, at the start.
      reset              = 1'b1;
      start              = 1'b0;
      req_opcode         = scc_pkg::OP_WRITE_ENTRY;
      req_sprite_index   = '0;
      req_sprite_x       = '0;
      req_sprite_y       = '0;
      req_sprite_width   = '0;
      req_sprite_height  = '0;
      req_pixel_format   = 1'b0;
      req_sprite_enabled = 1'b0;
      req_scan_row       = '0;
      req_column         = '0;
      req_source_pixel   = '0;
      csr_write_enable   = 1'b0;
      csr_index          = scc_pkg::CSR_SCAN_WIDTH;
      csr_write_data     = '0;
      foreach (aim_x[i]) begin
         aim_x[i] = 0;  aim_y[i] = 0;  aim_w[i] = 0;  aim_h[i] = 0;  aim_fmt[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset settings (width 640, no sync bits).
      composite(9, 0, 0, 32'hFFFF_FFFF);                    // entry never written: disabled
      write_sprite(0, 0, 0, 256, 256, scc_pkg::FMT_RGBA8888, 1'b1);
      composite(0, 0, 0, 32'hFFC0_C0C0);                    // top-left corner, full colour
      composite(0, 255, 255, 32'h00FF_FFFF);                // transparent
      composite(0, 256, 0, 32'hFFFF_FFFF);                  // row below the sprite
      write_sprite(1, 100, 0, 300, 511, scc_pkg::FMT_RGBA2222, 1'b1);   // oversized
      composite(1, 255, 255, 32'h0000_0080);                // last row and column
      composite(1, 300, 0, 32'hFFFF_FFFF);                  // beyond the clamped height
      write_sprite(2, 0, 0, 0, 10, scc_pkg::FMT_RGBA8888, 1'b1);        // zero width
      composite(2, 0, 0, 32'hFFFF_FFFF);
      write_sprite(3, 0, 0, 10, 0, scc_pkg::FMT_RGBA8888, 1'b1);        // zero height
      composite(3, 0, 0, 32'hFFFF_FFFF);
      write_sprite(4, -4, 1023, 8, 1, scc_pkg::FMT_RGBA2222, 1'b1);
      composite(4, 1023, 3, 32'h0000_00FF);                 // left of the line
      composite(4, 1023, 4, 32'hFFFF_FFFF);                 // first visible position
      composite(4, 1023, 8, 32'h0000_00FF);                 // column past the width
      write_sprite(5, 1023, -1024, 256, 256, scc_pkg::FMT_RGBA8888, 1'b1);
      composite(5, 0, 0, 32'hFFFF_FFFF);                    // rows all above the line
      write_sprite(6, -1024, 0, 256, 1, scc_pkg::FMT_RGBA8888, 1'b1);
      composite(6, 0, 255, 32'hFFFF_FFFF);                  // whole sprite off the left
      write_sprite(7, 600, 10, 256, 4, scc_pkg::FMT_RGBA8888, 1'b0);
      composite(7, 10, 0, 32'hFFFF_FFFF);                   // disabled entry

      // Widest line with every sync bit set: the far right edge becomes visible.
      drain_pipeline();
      csr_write(scc_pkg::CSR_SCAN_WIDTH, 1024);
      csr_write(scc_pkg::CSR_SYNC_BYTE, 255);
      write_sprite(63, 1023, 1023, 1, 1, scc_pkg::FMT_RGBA8888, 1'b1);
      composite(63, 1023, 0, 32'h0100_0000);
      composite(0, 0, 255, 32'h8000_4000);

      // Random phases, each under its own settings, extremes first.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin sw = 1024;                     sb = 255;                    end
            1: begin sw = 1;                        sb = 0;                      end
            2: begin sw = $urandom_range(1, 1024);  sb = $urandom_range(0, 255); end
            3: begin sw = 640;                      sb = $urandom_range(0, 255); end
            4: begin sw = $urandom_range(1, 64);    sb = 0;                      end
            default: begin sw = $urandom_range(512, 1024); sb = $urandom_range(0, 255); end
         endcase
         drain_pipeline();
         burst = 1'b0;
         csr_write(scc_pkg::CSR_SCAN_WIDTH, sw);
         csr_write(scc_pkg::CSR_SYNC_BYTE, sb);
         run_random_phase(PHASE_WORDS);
      end

      drain_pipeline();
      if (fail_count == 0) begin
         $display("** sprite_scanline_compositor: PASSED **");
      end else begin
         $display("** sprite_scanline_compositor: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/scc_pkg.sv
hw/rtl/scc_ram.sv
hw/rtl/scc_table.sv
hw/rtl/scc_shade.sv
hw/rtl/sprite_scanline_compositor.sv
verif/sprite_scanline_compositor_checker.sv
verif/sprite_scanline_compositor_tb.sv
